[rtl/asac_pkg.sv]
// Shared constants, types and helpers for the affine sprite alpha compositor.
`default_nettype none
package asac_pkg;

	// Frame geometry and fixed-point format
	localparam int MAX_WIDTH     = 64;
	localparam int MAX_HEIGHT    = 64;
	localparam int FRACTION_BITS = 8;
	localparam int FRAME_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W        = $clog2(FRAME_DEPTH);

	// Field and register widths
	localparam int COORD_W  = 6;
	localparam int PIX_W    = 32;
	localparam int COEF_W   = 16;
	localparam int OFS_W    = 24;
	localparam int SIZE_W   = 7;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 3;

	// Transform datapath widths
	localparam int PROD_W = COEF_W + COORD_W + 1;
	localparam int SUM_W  = ((PROD_W + 1 > OFS_W) ? PROD_W + 1 : OFS_W) + 2;
	localparam int T_W    = SUM_W - FRACTION_BITS;
	localparam int DIM_W  = 9;

	// Register reset values
	localparam logic [COEF_W-1:0] MATRIX_ONE = COEF_W'(1 << FRACTION_BITS);
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

	// Request codes
	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_DRAW = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_XX     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_XY     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_YX     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_YY     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd7;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MAP,
		ST_RDATA,
		ST_BLEND1,
		ST_BLEND2,
		ST_DONE
	} state_t;

	// Mapped draw location from the transform unit
	typedef struct packed {
		logic              hit;
		logic [ADDR_W-1:0] addr;
	} map_t;

	// floor(v / 255) for v <= 255*255
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [16:0] t;
		t = 17'(v) + 17'(v[15:8]) + 17'd1;
		return t[15:8];
	endfunction

endpackage
`default_nettype wire

[rtl/asac_frame_ram.sv]
// Target frame store: one write port, one registered read port.
`default_nettype none
module asac_frame_ram
	import asac_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [PIX_W-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [PIX_W-1:0]  rdata
);

	logic [PIX_W-1:0] mem [FRAME_DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[rtl/asac_xform.sv]
// Affine coordinate map with rounding and clipping against the target area.
`default_nettype none
module asac_xform
	import asac_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [COORD_W-1:0] sx,
	input  wire logic [COORD_W-1:0] sy,
	input  wire logic [COEF_W-1:0]  matrix_xx,
	input  wire logic [COEF_W-1:0]  matrix_xy,
	input  wire logic [COEF_W-1:0]  matrix_yx,
	input  wire logic [COEF_W-1:0]  matrix_yy,
	input  wire logic [OFS_W-1:0]   offset_x,
	input  wire logic [OFS_W-1:0]   offset_y,
	input  wire logic [SIZE_W-1:0]  target_width,
	input  wire logic [SIZE_W-1:0]  target_height,
	output map_t                    map
);

	logic signed [COORD_W:0]   sx_s, sy_s;
	logic signed [PROD_W-1:0]  p_xx, p_xy, p_yx, p_yy;
	logic signed [SUM_W-1:0]   sum_x, sum_y;
	logic signed [SUM_W-1:0]   sum_x_s1, sum_y_s1;
	logic signed [SUM_W-1:0]   rnd_x, rnd_y;
	logic signed [T_W-1:0]     tx, ty;
	logic [DIM_W-1:0]          w_lim, h_lim;
	logic [ADDR_W-1:0]         row_base;

	// Products and sums, registered
	assign sx_s = $signed({1'b0, sx});
	assign sy_s = $signed({1'b0, sy});
	assign p_xx = $signed(matrix_xx) * sx_s;
	assign p_yx = $signed(matrix_yx) * sy_s;
	assign p_xy = $signed(matrix_xy) * sx_s;
	assign p_yy = $signed(matrix_yy) * sy_s;
	assign sum_x = SUM_W'(p_xx) + SUM_W'(p_yx) + SUM_W'($signed(offset_x));
	assign sum_y = SUM_W'(p_xy) + SUM_W'(p_yy) + SUM_W'($signed(offset_y));

	always_ff @(posedge clk) begin
		if (en) begin
			sum_x_s1 <= sum_x;
			sum_y_s1 <= sum_y;
		end
	end

	// Round half up: add one half, then floor via arithmetic drop of fraction
	assign rnd_x = sum_x_s1 + SUM_W'(1 << (FRACTION_BITS - 1));
	assign rnd_y = sum_y_s1 + SUM_W'(1 << (FRACTION_BITS - 1));
	assign tx    = rnd_x[SUM_W-1:FRACTION_BITS];
	assign ty    = rnd_y[SUM_W-1:FRACTION_BITS];

	// Sizes above the physical frame act as the maximum
	assign w_lim = (DIM_W'(target_width) > DIM_W'(MAX_WIDTH)) ?
		DIM_W'(MAX_WIDTH) : DIM_W'(target_width);
	assign h_lim = (DIM_W'(target_height) > DIM_W'(MAX_HEIGHT)) ?
		DIM_W'(MAX_HEIGHT) : DIM_W'(target_height);

	assign row_base = ADDR_W'(ADDR_W'(ty) * ADDR_W'(MAX_WIDTH));

	assign map.hit  = !tx[T_W-1] && !ty[T_W-1] &&
		($unsigned(tx) < T_W'(w_lim)) && ($unsigned(ty) < T_W'(h_lim));
	assign map.addr = row_base + ADDR_W'(tx);

endmodule
`default_nettype wire

[rtl/asac_blend.sv]
// Alpha blend of a sprite pixel over a stored pixel: product stage, then divide and sum.
`default_nettype none
module asac_blend
	import asac_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [PIX_W-1:0] dst,
	input  wire logic [PIX_W-1:0] src,
	output logic      [PIX_W-1:0] result
);

	logic [7:0]  a, da, a_inv, da_inv;
	logic [15:0] pd [3];
	logic [15:0] ps [3];
	logic [15:0] pd_s1 [3];
	logic [15:0] ps_s1 [3];
	logic [15:0] pa_s1;
	logic [7:0]  da_s1;

	assign a      = src[31:24];
	assign da     = dst[31:24];
	assign a_inv  = 8'd255 - a;
	assign da_inv = 8'd255 - da;

	// Per-channel products
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			pd[c] = 16'(dst[c*8 +: 8]) * 16'(a_inv);
			ps[c] = 16'(src[c*8 +: 8]) * 16'(a);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pd_s1 <= pd;
			ps_s1 <= ps;
			pa_s1 <= 16'(a) * 16'(da_inv);
			da_s1 <= da;
		end
	end

	// Divide by 255 and combine
	always_comb begin
		result[31:24] = da_s1 + div255(pa_s1);
		for (int c = 0; c < 3; c++) begin
			result[c*8 +: 8] = div255(pd_s1[c]) + div255(ps_s1[c]);
		end
	end

endmodule
`default_nettype wire

[rtl/affine_sprite_alpha_compositor.sv]
// Top level of the affine sprite alpha compositor: registers, sequencer and output stage.
`default_nettype none
// Holds a 64x64 ARGB target frame in a synchronous memory with one write port and
// one read port, and serves one request at a time. A load writes a pixel, a read
// returns one, and a draw maps the sprite coordinate through the affine matrix
// (8 fraction bits, rounded half up), clips it to the target size and blends the
// sprite pixel over the stored one. Every request yields exactly one result
// transfer. A load writes in EXEC; a read takes the registered data in RDATA; a
// draw maps in MAP and, if it lands, reads the stored pixel, registers the blend
// products in BLEND1 and writes back in BLEND2. A finished result sits in the
// output register, so the next request is taken while it waits. The frame holds
// no defined contents after reset; pixels must be loaded before they are read or
// drawn over. Configuration is to be written only while no request is in flight;
// the block itself does not enforce this.
module affine_sprite_alpha_compositor
	import asac_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Configuration
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	// Request channel
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire logic [1:0]           req_type,
	input  wire logic [COORD_W-1:0]   coord_x,
	input  wire logic [COORD_W-1:0]   coord_y,
	input  wire logic [PIX_W-1:0]     pixel_argb,
	// Result channel
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output logic      [PIX_W-1:0]     read_argb,
	output logic                      landed
);

	logic [COEF_W-1:0] matrix_xx_q, matrix_xy_q, matrix_yx_q, matrix_yy_q;
	logic [OFS_W-1:0]  offset_x_q, offset_y_q;
	logic [SIZE_W-1:0] target_width_q, target_height_q;

	state_t state_q, state_d;

	logic [1:0]         req_q;
	logic [COORD_W-1:0] x_q, y_q;
	logic [PIX_W-1:0]   pix_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [PIX_W-1:0]   res_argb_q;
	logic               res_landed_q;

	logic               req_xfer;
	logic               out_free;
	logic               in_bounds;
	logic [ADDR_W-1:0]  xy_addr;
	map_t               map;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [PIX_W-1:0]   ram_wdata, ram_rdata;
	logic [PIX_W-1:0]   blend_res;
	logic               xform_en, blend_en;
	logic               set_res;
	logic [PIX_W-1:0]   set_argb;
	logic               set_landed;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_xx_q     <= MATRIX_ONE;
			matrix_xy_q     <= '0;
			matrix_yx_q     <= '0;
			matrix_yy_q     <= MATRIX_ONE;
			offset_x_q      <= '0;
			offset_y_q      <= '0;
			target_width_q  <= SIZE_RESET;
			target_height_q <= SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MATRIX_XX:     matrix_xx_q     <= cfg_data[COEF_W-1:0];
				CFG_MATRIX_XY:     matrix_xy_q     <= cfg_data[COEF_W-1:0];
				CFG_MATRIX_YX:     matrix_yx_q     <= cfg_data[COEF_W-1:0];
				CFG_MATRIX_YY:     matrix_yy_q     <= cfg_data[COEF_W-1:0];
				CFG_OFFSET_X:      offset_x_q      <= cfg_data[OFS_W-1:0];
				CFG_OFFSET_Y:      offset_y_q      <= cfg_data[OFS_W-1:0];
				CFG_TARGET_WIDTH:  target_width_q  <= cfg_data[SIZE_W-1:0];
				CFG_TARGET_HEIGHT: target_height_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign req_xfer = req_valid && req_ready;
	assign out_free = !res_valid || res_ready;

	// Request capture
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			req_q <= req_type;
			x_q   <= coord_x;
			y_q   <= coord_y;
			pix_q <= pixel_argb;
		end
	end

	// Physical frame addressing for load and read
	assign in_bounds = (int'(x_q) < MAX_WIDTH) && (int'(y_q) < MAX_HEIGHT);
	assign xy_addr   = ADDR_W'(ADDR_W'(y_q) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(x_q);

	// Sequencer: state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state and memory control
	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = xy_addr;
		ram_wdata  = pix_q;
		ram_raddr  = xy_addr;
		xform_en   = 1'b0;
		blend_en   = 1'b0;
		set_res    = 1'b0;
		set_argb   = '0;
		set_landed = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (req_q)
					REQ_LOAD: begin
						ram_we  = in_bounds;
						set_res = 1'b1;
						state_d = ST_DONE;
					end
					REQ_READ: begin
						state_d = ST_RDATA;
					end
					REQ_DRAW: begin
						xform_en = 1'b1;
						state_d  = ST_MAP;
					end
					default: begin
						set_res = 1'b1;
						state_d = ST_DONE;
					end
				endcase
			end
			ST_MAP: begin
				ram_raddr = map.addr;
				if (map.hit) begin
					state_d = ST_BLEND1;
				end else begin
					set_res = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_RDATA: begin
				set_res  = 1'b1;
				set_argb = in_bounds ? ram_rdata : '0;
				state_d  = ST_DONE;
			end
			ST_BLEND1: begin
				blend_en = 1'b1;
				state_d  = ST_BLEND2;
			end
			ST_BLEND2: begin
				ram_we     = 1'b1;
				ram_waddr  = addr_q;
				ram_wdata  = blend_res;
				set_res    = 1'b1;
				set_landed = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Draw address held for write back
	always_ff @(posedge clk) begin
		if (state_q == ST_MAP) begin
			addr_q <= map.addr;
		end
	end

	// Result staging
	always_ff @(posedge clk) begin
		if (set_res) begin
			res_argb_q   <= set_argb;
			res_landed_q <= set_landed;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			read_argb <= res_argb_q;
			landed    <= res_landed_q;
		end
	end

	asac_frame_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	asac_xform u_xform (
		.clk           (clk),
		.en            (xform_en),
		.sx            (x_q),
		.sy            (y_q),
		.matrix_xx     (matrix_xx_q),
		.matrix_xy     (matrix_xy_q),
		.matrix_yx     (matrix_yx_q),
		.matrix_yy     (matrix_yy_q),
		.offset_x      (offset_x_q),
		.offset_y      (offset_y_q),
		.target_width  (target_width_q),
		.target_height (target_height_q),
		.map           (map)
	);

	asac_blend u_blend (
		.clk    (clk),
		.en     (blend_en),
		.dst    (ram_rdata),
		.src    (pix_q),
		.result (blend_res)
	);

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// Testbench for the affine sprite alpha compositor with a request predictor and checker.
module testbench
	import asac_pkg::*;
();

	// Request code the block leaves unused
	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam int unsigned CHAN_MAX = 255;
	localparam int LONG_HOLD_AT = 2500;

	typedef struct {
		logic [1:0]         kind;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [PIX_W-1:0]   pix;
	} pixel_req_t;

	typedef struct {
		logic [PIX_W-1:0] read_argb;
		logic             landed;
	} pixel_res_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	logic [1:0]           req_type = REQ_LOAD;
	logic [COORD_W-1:0]   coord_x = '0;
	logic [COORD_W-1:0]   coord_y = '0;
	logic [PIX_W-1:0]     pixel_argb = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	logic [PIX_W-1:0]     read_argb;
	logic                 landed;

	// Transform settings as last written
	logic signed [COEF_W-1:0] m_xx = MATRIX_ONE;
	logic signed [COEF_W-1:0] m_xy = '0;
	logic signed [COEF_W-1:0] m_yx = '0;
	logic signed [COEF_W-1:0] m_yy = MATRIX_ONE;
	logic signed [OFS_W-1:0]  ofs_x = '0;
	logic signed [OFS_W-1:0]  ofs_y = '0;
	logic [SIZE_W-1:0]        size_w = SIZE_RESET;
	logic [SIZE_W-1:0]        size_h = SIZE_RESET;

	// Predicted frame contents, and which entries the stimulus has filled
	logic [PIX_W-1:0] frame_model [FRAME_DEPTH] = '{default: '0};
	bit               pixel_filled [FRAME_DEPTH];

	pixel_req_t pending_reqs[$];
	pixel_res_t expected_results[$];
	pixel_req_t offered_req;
	int         fail_count = 0;

	affine_sprite_alpha_compositor i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_type   (req_type),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.pixel_argb (pixel_argb),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.read_argb  (read_argb),
		.landed     (landed)
	);

	always #10 clk = ~clk;

	// Map a sprite coordinate into the target; returns 1 when it lands inside
	function automatic bit map_to_target(input logic [COORD_W-1:0] sx, sy, output int idx);
		longint tx, ty;
		int     w, h;
		tx = (longint'(m_xx) * longint'(sx) + longint'(m_yx) * longint'(sy)
			+ longint'(ofs_x) + (longint'(1) << (FRACTION_BITS - 1))) >>> FRACTION_BITS;
		ty = (longint'(m_xy) * longint'(sx) + longint'(m_yy) * longint'(sy)
			+ longint'(ofs_y) + (longint'(1) << (FRACTION_BITS - 1))) >>> FRACTION_BITS;
		w = (int'(size_w) > MAX_WIDTH) ? MAX_WIDTH : int'(size_w);
		h = (int'(size_h) > MAX_HEIGHT) ? MAX_HEIGHT : int'(size_h);
		idx = int'(ty) * MAX_WIDTH + int'(tx);
		return tx >= 0 && ty >= 0 && tx < w && ty < h;
	endfunction

	// Source-over blend, each division truncating
	function automatic logic [PIX_W-1:0] blend_over(input logic [PIX_W-1:0] dst, src);
		int unsigned      a, da, d, s;
		logic [PIX_W-1:0] r;
		a  = src[31:24];
		da = dst[31:24];
		r[31:24] = 8'(da + a * (CHAN_MAX - da) / CHAN_MAX);
		for (int k = 0; k < 3; k++) begin
			d = dst[8*k +: 8];
			s = src[8*k +: 8];
			r[8*k +: 8] = 8'(d * (CHAN_MAX - a) / CHAN_MAX + s * a / CHAN_MAX);
		end
		return r;
	endfunction

	// Expected answer to one request; updates the predicted frame
	function automatic pixel_res_t apply_request(input pixel_req_t rq);
		pixel_res_t r;
		int         idx;
		r.read_argb = '0;
		r.landed    = 1'b0;
		case (rq.kind)
			REQ_LOAD: begin
				frame_model[int'(rq.y) * MAX_WIDTH + int'(rq.x)] = rq.pix;
			end
			REQ_READ: begin
				r.read_argb = frame_model[int'(rq.y) * MAX_WIDTH + int'(rq.x)];
			end
			REQ_DRAW: begin
				if (map_to_target(rq.x, rq.y, idx)) begin
					frame_model[idx] = blend_over(frame_model[idx], rq.pix);
					r.landed = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		logic [7:0] a;
		case ($urandom_range(0, 3))
			0: a = 8'h00;
			1: a = 8'hFF;
			default: a = 8'($urandom);
		endcase
		return {a, 24'($urandom)};
	endfunction

	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return COORD_W'($urandom_range(0, MAX_WIDTH - 1));
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] rand_coef();
		return COEF_W'(int'($urandom_range(0, 1024)) - 512);
	endfunction

	task automatic queue_item(input logic [1:0] kind, input logic [COORD_W-1:0] x, y,
			input logic [PIX_W-1:0] pix);
		pixel_req_t rq;
		rq.kind = kind;
		rq.x    = x;
		rq.y    = y;
		rq.pix  = pix;
		if (kind == REQ_LOAD)
			pixel_filled[int'(y) * MAX_WIDTH + int'(x)] = 1'b1;
		pending_reqs.push_back(rq);
	endtask

	// Never touch an entry that holds no defined pixel: fill it first
	task automatic fill_if_empty(input int idx);
		if (!pixel_filled[idx])
			queue_item(REQ_LOAD, COORD_W'(idx % MAX_WIDTH), COORD_W'(idx / MAX_WIDTH),
				rand_pixel());
	endtask

	task automatic queue_draw(input logic [COORD_W-1:0] sx, sy, input logic [PIX_W-1:0] pix,
			output bit hit, output int idx);
		hit = map_to_target(sx, sy, idx);
		if (hit)
			fill_if_empty(idx);
		queue_item(REQ_DRAW, sx, sy, pix);
	endtask

	task automatic queue_read(input logic [COORD_W-1:0] x, y);
		fill_if_empty(int'(y) * MAX_WIDTH + int'(x));
		queue_item(REQ_READ, x, y, 32'($urandom));
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic load_transform(input logic [COEF_W-1:0] xx, xy, yx, yy,
			input logic [OFS_W-1:0] ox, oy, input logic [SIZE_W-1:0] w, h);
		cfg_write(CFG_MATRIX_XX, CFG_W'(xx));
		cfg_write(CFG_MATRIX_XY, CFG_W'(xy));
		cfg_write(CFG_MATRIX_YX, CFG_W'(yx));
		cfg_write(CFG_MATRIX_YY, CFG_W'(yy));
		cfg_write(CFG_OFFSET_X, CFG_W'(ox));
		cfg_write(CFG_OFFSET_Y, CFG_W'(oy));
		cfg_write(CFG_TARGET_WIDTH, CFG_W'(w));
		cfg_write(CFG_TARGET_HEIGHT, CFG_W'(h));
		m_xx   = xx;
		m_xy   = xy;
		m_yx   = yx;
		m_yy   = yy;
		ofs_x  = ox;
		ofs_y  = oy;
		size_w = w;
		size_h = h;
	endtask

	// Wait for every request to be taken and answered, then let the pipeline settle
	task automatic drain();
		while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Request driver: bursts of random length separated by random gaps
	always @(posedge clk) begin : req_driver
		static int burst_left = 0;
		static int gap_left = 0;
		bit        offer_next;
		bit        taken;
		pixel_req_t rq;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			offer_next = 1'b0;
			taken = req_valid && req_ready;
			if (taken) begin
				expected_results.push_back(apply_request(offered_req));
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 7);
				else
					offer_next = 1'b1;
			end else if (!req_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					offer_next = 1'b1;
					if (burst_left == 0)
						burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
				end
			end
			if (offer_next && pending_reqs.size() != 0) begin
				rq = pending_reqs.pop_front();
				offered_req = rq;
				req_valid  <= 1'b1;
				req_type   <= rq.kind;
				coord_x    <= rq.x;
				coord_y    <= rq.y;
				pixel_argb <= rq.pix;
			end else if (taken) begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stall patterns, plus long hold-offs
	always @(posedge clk) begin : res_receiver
		static int rx_cycle = 0;
		static int rx_mode = 0;
		static int hold_left = 0;
		static bit long_done = 1'b0;
		logic      ready_next;
		rx_cycle++;
		if (rx_cycle % 50 == 0)
			rx_mode = $urandom_range(0, 3);
		// One long hold-off while plenty of requests are still queued to be offered
		if (!long_done && rx_cycle >= LONG_HOLD_AT && pending_reqs.size() > 8) begin
			long_done = 1'b1;
			hold_left = $urandom_range(150, 300);
		end else if ($urandom_range(0, 4999) == 0) begin
			hold_left = $urandom_range(150, 300);
		end
		if (hold_left > 0) begin
			hold_left--;
			ready_next = 1'b0;
		end else begin
			case (rx_mode)
				0: ready_next = 1'b1;
				1: ready_next = $urandom_range(0, 1);
				2: ready_next = ($urandom_range(0, 3) == 0);
				default: ready_next = ($urandom_range(0, 9) != 0);
			endcase
		end
		res_ready <= ready_next;
	end

	// Result checker
	always @(posedge clk) begin : res_checker
		pixel_res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with none expected, read_argb %h landed %b",
					$time, read_argb, landed);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (read_argb !== want.read_argb) begin
					$display("%0t: read_argb expected %h, actual %h",
						$time, want.read_argb, read_argb);
					fail_count++;
				end
				if (landed !== want.landed) begin
					$display("%0t: landed expected %b, actual %b", $time, want.landed, landed);
					fail_count++;
				end
			end
		end
	end

	// Stimulus and end of run
	initial begin : stimulus
		bit   hit;
		int   idx;
		int   n_items;
		int   pick;
		logic [COORD_W-1:0] sx, sy;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: corners, opaque and clear alpha, back-to-back draws, spare code
		queue_item(REQ_LOAD, 6'd0, 6'd0, 32'hFFFF_FFFF);
		queue_item(REQ_LOAD, 6'd63, 6'd63, 32'h0000_0000);
		queue_item(REQ_LOAD, 6'd63, 6'd0, 32'h80FF_7F01);
		queue_item(REQ_LOAD, 6'd0, 6'd63, 32'h7F00_FF80);
		queue_read(6'd0, 6'd0);
		queue_read(6'd63, 6'd63);
		queue_draw(6'd0, 6'd0, 32'hFF10_2030, hit, idx);
		queue_draw(6'd63, 6'd63, 32'h00FF_FFFF, hit, idx);
		queue_draw(6'd63, 6'd0, 32'h80A0_B0C0, hit, idx);
		queue_draw(6'd0, 6'd63, 32'h01FF_FFFF, hit, idx);
		queue_draw(6'd0, 6'd0, 32'h7F7F_7F7F, hit, idx);
		queue_read(6'd0, 6'd0);
		queue_read(6'd63, 6'd0);
		queue_read(6'd0, 6'd63);
		queue_read(6'd63, 6'd63);
		queue_item(REQ_SPARE, 6'd21, 6'd42, 32'hA5A5_5A5A);
		drain();

		// Half-pixel offsets and clipping on the right and top edges
		load_transform(16'd256, 16'd0, 16'd0, 16'd256, -24'sd128, -24'sd129, 7'd5, 7'd64);
		queue_draw(6'd5, 6'd0, 32'hFFFF_FFFF, hit, idx);
		queue_draw(6'd4, 6'd1, 32'hC0FF_FFFF, hit, idx);
		queue_draw(6'd5, 6'd1, 32'hFF00_0000, hit, idx);
		queue_draw(6'd0, 6'd0, 32'h8012_3456, hit, idx);
		queue_read(6'd4, 6'd0);
		drain();

		for (int ph = 0; ph < 16; ph++) begin
			n_items = 85;
			case (ph)
				0: load_transform(16'd256, 16'd0, 16'd0, 16'd256, 24'd0, 24'd0,
					7'd64, 7'd64);
				1: begin
					load_transform(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
						24'h7F_FFFF, 24'h80_0000, 7'd64, 7'd64);
					n_items = 40;
				end
				2: begin
					load_transform(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
						24'd0, 24'd0, 7'd64, 7'd64);
					n_items = 40;
				end
				3: begin
					load_transform(16'd256, 16'd0, 16'd0, 16'd256, 24'd0, 24'd0, 7'd0, 7'd64);
					n_items = 40;
				end
				4: begin
					load_transform(16'd256, 16'd0, 16'd0, 16'd256, 24'($urandom_range(0, 255)),
						24'($urandom_range(0, 255)), 7'd127, 7'd65);
					n_items = 120;
				end
				5: begin
					load_transform(16'd256, 16'd0, 16'd0, 16'd256, 24'd0, 24'd0, 7'd1, 7'd1);
					n_items = 60;
				end
				6: load_transform(16'd512, 16'd0, 16'd0, 16'd512, 24'd0, 24'd0,
					7'd64, 7'd64);
				7: load_transform(16'd128, 16'd0, 16'd0, 16'd128, 24'd0, 24'd0,
					7'd64, 7'd64);
				8: load_transform(16'd0, 16'd256, 16'd256, 16'd0, 24'd0, 24'd0,
					7'd64, 7'd48);
				default: begin
					load_transform(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
						24'(int'($urandom_range(0, 24576)) - 8192),
						24'(int'($urandom_range(0, 24576)) - 8192),
						($urandom_range(0, 9) < 7) ? 7'd64 : 7'($urandom_range(1, 64)),
						($urandom_range(0, 9) < 7) ? 7'd64 : 7'($urandom_range(1, 64)));
				end
			endcase

			// Mostly draws, with read-back and repeated draws onto the same pixel
			for (int n = 0; n < n_items; n++) begin
				pick = $urandom_range(0, 99);
				sx = rand_coord();
				sy = rand_coord();
				if (pick < 10) begin
					queue_item(REQ_LOAD, sx, sy, rand_pixel());
				end else if (pick < 65) begin
					queue_draw(sx, sy, rand_pixel(), hit, idx);
					if (hit) begin
						case ($urandom_range(0, 5))
							0: queue_read(COORD_W'(idx % MAX_WIDTH),
								COORD_W'(idx / MAX_WIDTH));
							1: queue_draw(sx, sy, rand_pixel(), hit, idx);
							default: ;
						endcase
					end
				end else if (pick < 95) begin
					queue_read(sx, sy);
				end else begin
					queue_item(REQ_SPARE, sx, sy, 32'($urandom));
				end
			end
			drain();
		end

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Run limit
	initial begin : watchdog
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
